/* design/pid_alloc_pkg.sv */
// shared types, codes and helpers for the process identifier allocator
package pid_alloc_pkg;

    // map storage word and result widths
    localparam int WORD_W   = 8;
    localparam int BIT_W    = 3;
    localparam int ID_OUT_W = 8;
    localparam int ID_EXT_W = 13;
    localparam int ID_CAT_W = 16;

    // request kinds carried on tuser
    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // result status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NONE_FREE = 1'b1;

    localparam logic [WORD_W-1:0] BIT_ONE = 8'h01;

    // commands from the controller to the datapath
    typedef struct packed {
        logic take;       // capture request payload
        logic cnt_clr;    // word counter back to zero
        logic cnt_inc;    // word counter step
        logic clr_wr;     // clearing pass write
        logic scan_rd;    // scan read at word counter
        logic alloc_wr;   // mark the found identifier used
        logic rel_rd;     // read word of released identifier
        logic rel_wr;     // clear bit of released identifier
        logic res_alloc;  // latch allocate result
        logic res_full;   // latch none-free result
        logic res_rel;    // latch release echo
        logic push;       // move latched result to output register
    } pid_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic cnt_last;     // counter on the last map word
        logic cnt_done;     // counter past the last map word
        logic found;        // scanned word has a free identifier
        logic exhausted;    // last word scanned and nothing free
        logic rel_in_range; // released identifier lies inside the map
        logic out_free;     // output register can take a result
    } pid_sts_t;

    // position of the lowest zero bit, zero when the word is all ones
    function automatic logic [BIT_W-1:0] find_first_zero(input logic [WORD_W-1:0] word);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

/* design/pid_alloc_ram.sv */
// generic single write port, single read port ram with registered read
module pid_alloc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/pid_alloc_ctrl.sv */
// controller state machine for the process identifier allocator
module pid_alloc_ctrl
    import pid_alloc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    input  logic     req_type,
    output logic     s_tready,
    input  pid_sts_t sts,
    output pid_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_REL_RD,
        ST_REL_WR,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.cnt_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.take   = 1'b1;
                    state_next = (req_type == REQ_ALLOC) ? ST_SCAN : ST_REL_RD;
                end
            end
            ST_SCAN:
            begin
                if (sts.found)
                begin
                    cmd.alloc_wr  = 1'b1;
                    cmd.res_alloc = 1'b1;
                    cmd.cnt_clr   = 1'b1;
                    state_next    = ST_RESULT;
                end
                else if (sts.exhausted)
                begin
                    cmd.res_full = 1'b1;
                    cmd.cnt_clr  = 1'b1;
                    state_next   = ST_RESULT;
                end
                else if (!sts.cnt_done)
                begin
                    cmd.scan_rd = 1'b1;
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_REL_RD:
            begin
                if (sts.rel_in_range)
                begin
                    cmd.rel_rd = 1'b1;
                    state_next = ST_REL_WR;
                end
                else
                begin
                    cmd.res_rel = 1'b1;
                    state_next  = ST_RESULT;
                end
            end
            ST_REL_WR:
            begin
                cmd.rel_wr  = 1'b1;
                cmd.res_rel = 1'b1;
                state_next  = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/pid_alloc_dp.sv */
// datapath: bitmap ram, word counter, find-first-zero and result registers
module pid_alloc_dp
    import pid_alloc_pkg::*;
#(
    parameter int ID_COUNT = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pid_cmd_t            cmd,
    output pid_sts_t            sts,
    input  logic [ID_OUT_W-1:0] release_id,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [ID_OUT_W-1:0] granted_id,
    output logic                status
);

    localparam int WORDS     = (ID_COUNT + WORD_W - 1) / WORD_W;
    localparam int ADDR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_W     = $clog2(WORDS + 1);
    localparam int LAST_BITS = ID_COUNT - (WORDS - 1) * WORD_W;
    localparam logic [WORD_W-1:0] LAST_MASK = WORD_W'((1 << LAST_BITS) - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WORDS - 1);

    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ID_OUT_W-1:0] rel_reg, rel_next;
    logic                rd_live_reg, rd_live_next;
    logic [ADDR_W-1:0]   rd_word_reg, rd_word_next;
    logic [ID_OUT_W-1:0] res_id_reg, res_id_next;
    logic                res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [ID_OUT_W-1:0] out_id_reg, out_id_next;
    logic                out_status_reg, out_status_next;

    logic [ADDR_W-1:0]   cnt_addr;
    logic [ID_EXT_W-1:0] rel_wide;
    logic [ADDR_W-1:0]   rel_word;
    logic [BIT_W-1:0]    rel_bit;
    logic [WORD_W-1:0]   rdata;
    logic [WORD_W-1:0]   valid_mask;
    logic [WORD_W-1:0]   masked;
    logic                has_free;
    logic [BIT_W-1:0]    ff_bit;
    logic [ID_CAT_W-1:0] gid_wide;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;

    assign cnt_addr = cnt_reg[ADDR_W-1:0];
    assign rel_wide = ID_EXT_W'(rel_reg);
    assign rel_word = rel_wide[ADDR_W+BIT_W-1:BIT_W];
    assign rel_bit  = rel_reg[BIT_W-1:0];

    // bits past the end of the map read as used
    assign valid_mask = (rd_word_reg == LAST_ADDR) ? LAST_MASK : '1;
    assign masked     = rdata | ~valid_mask;
    assign has_free   = (masked != '1);
    assign ff_bit     = find_first_zero(masked);
    assign gid_wide   = ID_CAT_W'({rd_word_reg, ff_bit});

    assign sts.cnt_last     = (cnt_reg == CNT_W'(WORDS - 1));
    assign sts.cnt_done     = (cnt_reg == CNT_W'(WORDS));
    assign sts.found        = rd_live_reg && has_free;
    assign sts.exhausted    = rd_live_reg && !has_free && (rd_word_reg == LAST_ADDR);
    assign sts.rel_in_range = (rel_wide < ID_EXT_W'(ID_COUNT));
    assign sts.out_free     = !out_valid_reg || m_tready;

    // ram port steering
    always_comb
    begin
        ram_re    = cmd.scan_rd || cmd.rel_rd;
        ram_raddr = cmd.scan_rd ? cnt_addr : rel_word;
        ram_we    = cmd.clr_wr || cmd.alloc_wr || cmd.rel_wr;
        ram_waddr = cnt_addr;
        ram_wdata = '0;
        if (cmd.alloc_wr)
        begin
            ram_waddr = rd_word_reg;
            ram_wdata = rdata | (BIT_ONE << ff_bit);
        end
        else if (cmd.rel_wr)
        begin
            ram_waddr = rel_word;
            ram_wdata = rdata & ~(BIT_ONE << rel_bit);
        end
    end

    pid_alloc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        end
        rel_next     = cmd.take ? release_id : rel_reg;
        rd_live_next = cmd.scan_rd;
        rd_word_next = cmd.scan_rd ? cnt_addr : rd_word_reg;

        res_id_next     = res_id_reg;
        res_status_next = res_status_reg;
        if (cmd.res_alloc)
        begin
            res_id_next     = gid_wide[ID_OUT_W-1:0];
            res_status_next = STATUS_OK;
        end
        else if (cmd.res_full)
        begin
            res_id_next     = '0;
            res_status_next = STATUS_NONE_FREE;
        end
        else if (cmd.res_rel)
        begin
            res_id_next     = rel_reg;
            res_status_next = STATUS_OK;
        end

        out_valid_next  = out_valid_reg && !m_tready;
        out_id_next     = out_id_reg;
        out_status_next = out_status_reg;
        if (cmd.push)
        begin
            out_valid_next  = 1'b1;
            out_id_next     = res_id_reg;
            out_status_next = res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rd_live_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            rd_live_reg   <= rd_live_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rel_reg        <= rel_next;
        rd_word_reg    <= rd_word_next;
        res_id_reg     <= res_id_next;
        res_status_reg <= res_status_next;
        out_id_reg     <= out_id_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign granted_id = out_id_reg;
    assign status     = out_status_reg;

    a_alloc_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_wr |-> (rd_live_reg && has_free))
        else $error("allocate write without a free bit in the scanned word");

    a_scan_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_rd |-> !sts.cnt_done)
        else $error("scan read past the end of the map");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!out_valid_reg || m_tready))
        else $error("result pushed over an untaken result");

    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_wr, cmd.alloc_wr, cmd.rel_wr}))
        else $error("more than one map write source active");

endmodule

/* design/process_id_bitmap_allocator.sv */
// top level of the process identifier bitmap allocator
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+-------------------------------------
//  s_*     | in  | s_tvalid / s_tready       | tdata: release_id; tuser: req_type
//  m_*     | out | m_tvalid / m_tready       | tdata: granted_id; tuser: status
//
//  after reset a clearing pass writes every map byte, ceil(ID_COUNT/8) of them,
//  to free, one byte per cycle, with s_tready low throughout
//  a release request reads the map byte, then clears the identifier's bit, then pushes
//  the result (off the map it skips the read and clear); an allocate request scans the
//  map one byte per cycle from byte 0 and grants the lowest free identifier, or returns
//  none-free when the map is full; the byte-wide map ram read port sets this pace
//  one request is in flight at a time; the output register lets the next request
//  be taken while a result waits on m_tready
module process_id_bitmap_allocator
    import pid_alloc_pkg::*;
#(
    parameter int ID_COUNT = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    // request channel
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] release_id
    input  logic       s_tuser,   // [0] req_type
    // result channel
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] granted_id
    output logic       m_tuser    // [0] status
);

    pid_cmd_t cmd;
    pid_sts_t sts;

    // controller: sequences clearing, scan and release steps
    pid_alloc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: map ram, find-first-zero and result registers
    pid_alloc_dp #(
        .ID_COUNT (ID_COUNT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .release_id (s_tdata),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .granted_id (m_tdata),
        .status     (m_tuser)
    );

endmodule

/* sim/tb_top.sv */
// self-checking testbench for the process identifier bitmap allocator
module tb_top;
    import pid_alloc_pkg::*;

    localparam int ID_TOTAL      = 256;
    localparam int RANDOM_ITEMS  = 1550;
    localparam int HOLD_OFF      = 300;   // long receiver hold-off, in cycles
    localparam int DRAIN_CYCLES  = 48;

    // one expected result as it should leave the m_ channel
    typedef struct packed {
        logic [7:0] granted_id;
        logic       status;
    } grant_t;

    // mirror of the used map, the queue of expected results and the checks on them
    class pid_map_tracker;
        bit [ID_TOTAL-1:0] id_used;
        grant_t            pending_grants[$];
        int                errors;
        int                allocs_done;
        int                releases_done;
        int                none_free_seen;
        int                results_seen;

        function new();
            id_used        = '0;
            errors         = 0;
            allocs_done    = 0;
            releases_done  = 0;
            none_free_seen = 0;
            results_seen   = 0;
        endfunction

        // apply an accepted request to the mirror and queue its result
        function void note_request(logic kind, logic [7:0] rel_id);
            grant_t g;
            int     slot;
            slot = -1;
            if (kind == REQ_ALLOC)
            begin
                for (int i = 0; i < ID_TOTAL; i++)
                begin
                    if (slot < 0 && !id_used[i])
                    begin
                        slot = i;
                    end
                end
                if (slot < 0)
                begin
                    // map full: zero id, none-free status, map untouched
                    g.granted_id = '0;
                    g.status     = STATUS_NONE_FREE;
                    none_free_seen++;
                end
                else
                begin
                    id_used[slot] = 1'b1;
                    g.granted_id  = 8'(slot);
                    g.status      = STATUS_OK;
                    allocs_done++;
                end
            end
            else
            begin
                // release of a free id leaves the map as it is, still echoed
                if (int'(rel_id) < ID_TOTAL)
                begin
                    id_used[rel_id] = 1'b0;
                end
                g.granted_id = rel_id;
                g.status     = STATUS_OK;
                releases_done++;
            end
            pending_grants.push_back(g);
        endfunction

        function void check_result(logic [7:0] got_id, logic got_status);
            grant_t g;
            results_seen++;
            if (pending_grants.size() == 0)
            begin
                $error("unexpected result: granted_id %0d status %0d", got_id, got_status);
                errors++;
                return;
            end
            g = pending_grants.pop_front();
            if (got_id !== g.granted_id)
            begin
                $error("granted_id expected %0d actual %0d", g.granted_id, got_id);
                errors++;
            end
            if (got_status !== g.status)
            begin
                $error("status expected %0d actual %0d", g.status, got_status);
                errors++;
            end
        endfunction

        // some identifier currently in use, or any identifier when the map is empty
        function logic [7:0] some_used_id();
            int start;
            start = $urandom_range(0, ID_TOTAL - 1);
            for (int k = 0; k < ID_TOTAL; k++)
            begin
                if (id_used[(start + k) % ID_TOTAL])
                begin
                    return 8'((start + k) % ID_TOTAL);
                end
            end
            return 8'(start);
        endfunction

        function int in_use();
            return $countones(id_used);
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;     // [7:0] release_id
    logic       s_tuser = 1'b0;   // [0] req_type
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;          // [7:0] granted_id
    logic       m_tuser;          // [0] status

    pid_map_tracker tracker;
    bit             burst_mode = 1'b0;   // no random pauses on either side while set
    bit             sink_hold_req = 1'b0;
    int             peak_in_use = 0;

    process_id_bitmap_allocator #(
        .ID_COUNT (ID_TOTAL)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // idle length: mostly none, some short, a few long
    function automatic int pick_pause();
        int roll;
        roll = $urandom_range(0, 99);
        if (burst_mode || roll < 65)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // offer one request and hold it until the block takes it
    task automatic send_request(input logic kind, input logic [7:0] rel_id);
        int pause;
        pause = pick_pause();
        if (pause > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= rel_id;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        // accepted at this edge, so the mirror moves on in request order
        tracker.note_request(kind, rel_id);
        if (tracker.in_use() > peak_in_use)
        begin
            peak_in_use = tracker.in_use();
        end
    endtask

    // allocate with a random don't-care payload on tdata
    task automatic send_alloc();
        send_request(REQ_ALLOC, 8'($urandom_range(0, 255)));
    endtask

    // result side: sample every accepted result at the clock edge
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            tracker.check_result(m_tdata, m_tuser);
        end
    end

    // result side: tready pattern, plus one long hold-off on request
    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
            end
            stall = pick_pause();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // hard limit well beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("process_id_bitmap_allocator: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        int   alloc_pct;
        int   roll;
        logic kind;
        logic [7:0] rel_id;

        tracker = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        // the clearing pass keeps s_tready low, send_request simply waits it out

        // directed part
        send_request(REQ_RELEASE, 8'd255);   // release of an id that is already free
        send_alloc();                         // 0
        send_alloc();                         // 1
        send_alloc();                         // 2
        send_request(REQ_RELEASE, 8'd1);
        send_alloc();                         // lowest hole is reused
        send_request(REQ_RELEASE, 8'd0);
        send_request(REQ_RELEASE, 8'd0);      // double release
        send_request(REQ_ALLOC, 8'hFF);       // payload is ignored on allocate
        send_request(REQ_ALLOC, 8'h00);
        send_request(REQ_RELEASE, 8'hAA);
        send_request(REQ_RELEASE, 8'h55);
        send_request(REQ_RELEASE, 8'd2);
        send_request(REQ_RELEASE, 8'd128);
        send_alloc();

        // random part in phases: fill past full, drain, fill again, then mixed
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n < 400)
            begin
                alloc_pct = 85;
            end
            else if (n < 700)
            begin
                alloc_pct = 15;
            end
            else if (n < 1100)
            begin
                alloc_pct = 85;
            end
            else
            begin
                alloc_pct = 50;
            end
            if (n % 100 == 0)
            begin
                burst_mode = ($urandom_range(0, 3) == 0);
            end
            if (n == 200)
            begin
                // back-pressure: receiver stalls long while requests keep coming
                burst_mode    = 1'b1;
                sink_hold_req = 1'b1;
            end
            roll = $urandom_range(0, 99);
            kind = (roll < alloc_pct) ? REQ_ALLOC : REQ_RELEASE;
            if (kind == REQ_ALLOC)
            begin
                send_alloc();
            end
            else
            begin
                // mostly ids that are in use, some arbitrary ones
                if ($urandom_range(0, 9) < 7)
                begin
                    rel_id = tracker.some_used_id();
                end
                else
                begin
                    rel_id = 8'($urandom_range(0, 255));
                end
                send_request(REQ_RELEASE, rel_id);
            end
        end
        s_tvalid <= 1'b0;
        burst_mode = 1'b0;

        // let every expected result arrive, then wait out the drain margin for strays
        while (tracker.pending_grants.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d grants, %0d releases, %0d none-free replies, %0d results checked",
                 tracker.allocs_done, tracker.releases_done, tracker.none_free_seen,
                 tracker.results_seen);
        $display("map occupancy peaked at %0d of %0d identifiers", peak_in_use, ID_TOTAL);
        if (tracker.errors == 0 && tracker.pending_grants.size() == 0)
        begin
            $display("process_id_bitmap_allocator: match");
        end
        else
        begin
            $display("process_id_bitmap_allocator: mismatch");
        end
        $finish;
    end

endmodule
